// ===== hw/rtl/mhdcp_pkg.sv =====
// Types, constants and fixed-point helpers shared by the MHD conversion pipeline.
package mhdcp_pkg;

    typedef logic signed [63:0] t_s64;

    // Command codes
    localparam logic CMD_C2P = 1'b0;
    localparam logic CMD_P2C = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_DENSITY_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_PRESSURE_FLOOR = 3'd1;
    localparam logic [2:0] CFG_GAMMA_LESS_ONE = 3'd2;
    localparam logic [2:0] CFG_INV_GAMMA_L1   = 3'd3;
    localparam logic [2:0] CFG_INV_PERM       = 3'd4;

    // Divider depth: one quotient bit per stage after one setup stage
    localparam int DIV_STEPS = 64;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    // Input register, three front stages, divider, ten back stages, output register
    localparam int PIPE_LAT  = 4 + DIV_LAT + 11;

    localparam t_s64 S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_DENS = 2'd1,
        REP_ENER = 2'd2,
        REP_PRES = 2'd3
    } t_repair;

    typedef struct packed {
        logic              cmd;
        logic signed [63:0] density_in;
        logic signed [63:0] vec_r_in;
        logic signed [63:0] vec_ph_in;
        logic signed [63:0] vec_th_in;
        logic signed [63:0] mag_r_in;
        logic signed [63:0] mag_ph_in;
        logic signed [63:0] mag_th_in;
        logic signed [63:0] scalar_in;
    } t_in;

    typedef struct packed {
        logic signed [63:0] density_out;
        logic signed [63:0] vec_r_out;
        logic signed [63:0] vec_ph_out;
        logic signed [63:0] vec_th_out;
        logic signed [63:0] mag_r_out;
        logic signed [63:0] mag_ph_out;
        logic signed [63:0] mag_th_out;
        logic signed [63:0] scalar_out;
        logic signed [63:0] energy_fixed;
        logic [1:0]         repair_code;
    } t_out;

    // Partial products of one magnitude multiply
    typedef struct packed {
        logic        neg;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    // Everything one transaction carries down the pipeline
    typedef struct packed {
        logic         vld;
        logic         cmd;
        t_repair      code;
        t_s64         rho;
        t_s64 [2:0]   v;
        t_s64 [2:0]   b;
        t_s64         s;
        t_pp  [2:0]   ppa;
        t_pp  [2:0]   ppb;
        t_pp  [2:0]   ppc;
        t_pp          ppx;
        t_pp          ppy;
        t_pp          ppz;
        t_s64 [2:0]   qa;
        t_s64 [2:0]   qb;
        t_s64 [2:0]   qc;
        t_s64 [2:0]   o;
        t_s64         b2;
        t_s64         a2;
        t_s64         qd;
        t_s64         bip;
        t_s64         pfig;
        t_s64         v2;
        t_s64         k;
        t_s64         erb;
        t_s64         e;
        t_s64         rv2;
        t_s64         sig;
        t_s64         hb;
        t_s64         p;
        t_s64         en;
        t_s64         efl;
    } t_work;

    function automatic logic [63:0] f_mag(input t_s64 x);
        f_mag = x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic t_s64 f_ssat(input logic neg, input logic [63:0] m);
        if (neg) begin
            f_ssat = m[63] ? S64_MIN : -$signed(m);
        end else begin
            f_ssat = m[63] ? S64_MAX : $signed(m);
        end
    endfunction

    function automatic t_s64 f_sadd(input t_s64 a, input t_s64 b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            f_sadd = s[64] ? S64_MIN : S64_MAX;
        end else begin
            f_sadd = s[63:0];
        end
    endfunction

    function automatic t_s64 f_ssub(input t_s64 a, input t_s64 b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            f_ssub = s[64] ? S64_MIN : S64_MAX;
        end else begin
            f_ssub = s[63:0];
        end
    endfunction

    // Halve, truncating toward zero
    function automatic t_s64 f_half(input t_s64 x);
        t_s64 t;
        t = x >>> 1;
        if (x[63] && x[0]) begin
            t = t + 64'sd1;
        end
        f_half = t;
    endfunction

    // First multiply stage: four 32x32 partial products of the magnitudes
    function automatic t_pp f_pp(input t_s64 a, input t_s64 b);
        logic [63:0] ma;
        logic [63:0] mb;
        t_pp r;
        ma = f_mag(a);
        mb = f_mag(b);
        r.neg = a[63] ^ b[63];
        r.p00 = 64'(ma[31:0]) * 64'(mb[31:0]);
        r.p01 = 64'(ma[31:0]) * 64'(mb[63:32]);
        r.p10 = 64'(ma[63:32]) * 64'(mb[31:0]);
        r.p11 = 64'(ma[63:32]) * 64'(mb[63:32]);
        f_pp = r;
    endfunction

    // Second multiply stage: combine, keep Q32.32, saturate
    function automatic t_s64 f_fin(input t_pp x);
        logic [65:0] mid;
        logic [65:0] hi;
        mid = 66'(x.p00[63:32]) + 66'(x.p01[31:0]) + 66'(x.p10[31:0]);
        hi  = 66'(x.p11) + 66'(x.p01[63:32]) + 66'(x.p10[63:32]) + 66'(mid[65:32]);
        if (hi[65:32] != 34'd0) begin
            f_fin = x.neg ? S64_MIN : S64_MAX;
        end else begin
            f_fin = f_ssat(x.neg, {hi[31:0], mid[31:0]});
        end
    endfunction

    // Drop the valid bit of a stage while reset is asserted
    function automatic t_work f_gate_vld(input t_work w, input logic keep);
        t_work r;
        r = w;
        r.vld = w.vld & keep;
        f_gate_vld = r;
    endfunction

endpackage

// ===== hw/rtl/mhdcp_div_pipe.sv =====
// Pipelined Q32.32 signed divider, one quotient bit per stage.
module mhdcp_div_pipe (
    input  logic           i_clk,
    input  mhdcp_pkg::t_s64 i_num,
    input  mhdcp_pkg::t_s64 i_den,
    output mhdcp_pkg::t_s64 o_quo
);
    import mhdcp_pkg::*;

    logic [63:0] r_rem  [0:DIV_STEPS];
    logic [63:0] r_nl   [0:DIV_STEPS];
    logic [63:0] r_q    [0:DIV_STEPS];
    logic [63:0] r_d    [0:DIV_STEPS];
    logic        r_neg  [0:DIV_STEPS];
    logic        r_zero [0:DIV_STEPS];
    logic        r_sat  [0:DIV_STEPS];

    logic [63:0] n_n;
    logic [63:0] n_d;

    // Setup: magnitudes, sign and the cases that skip the long division
    always_comb begin
        n_n = f_mag(i_num);
        n_d = f_mag(i_den);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= {32'd0, n_n[63:32]};
        r_nl[0]   <= {n_n[31:0], 32'd0};
        r_q[0]    <= 64'd0;
        r_d[0]    <= n_d;
        r_neg[0]  <= i_num[63] ^ i_den[63];
        r_zero[0] <= (n_n == 64'd0);
        r_sat[0]  <= (n_d == 64'd0) || ({32'd0, n_n[63:32]} >= n_d);
    end

    // Restoring division, one bit a stage
    for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
        logic [64:0] n_rr;
        logic        n_ge;
        always_comb begin
            n_rr = {r_rem[g-1], r_nl[g-1][63]};
            n_ge = (n_rr >= {1'b0, r_d[g-1]});
        end
        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_ge ? 64'(n_rr - {1'b0, r_d[g-1]}) : n_rr[63:0];
            r_nl[g]   <= {r_nl[g-1][62:0], 1'b0};
            r_q[g]    <= {r_q[g-1][62:0], n_ge};
            r_d[g]    <= r_d[g-1];
            r_neg[g]  <= r_neg[g-1];
            r_zero[g] <= r_zero[g-1];
            r_sat[g]  <= r_sat[g-1];
        end
    end

    // Select the special results or the signed quotient
    always_comb begin
        if (r_zero[DIV_STEPS]) begin
            o_quo = 64'sd0;
        end else if (r_sat[DIV_STEPS]) begin
            o_quo = r_neg[DIV_STEPS] ? S64_MIN : S64_MAX;
        end else begin
            o_quo = f_ssat(r_neg[DIV_STEPS], r_q[DIV_STEPS]);
        end
    end

endmodule

// ===== hw/rtl/mhd_cons_prim_convert_top.sv =====
// Ideal-MHD conservative/primitive conversion pipeline, Q32.32 fixed point.
//
// One cell state enters on any cycle with i_start high (o_busy is always low).
// o_done rises for one cycle once the cell has passed the input register, the
// front stages, the divider, the back stages and the output register, and the
// result on o_result is valid with it; a new transaction can enter every cycle,
// so the sustained rate is one cell per clock. The 65-stage divider that forms
// velocity from momentum at one quotient bit per stage makes up most of the
// depth; the remaining stages are pipelined multiplies and saturating adds.
// Configuration writes take effect at once and belong to idle periods.
module mhd_cons_prim_convert_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  mhdcp_pkg::t_in    i_item,
    output logic              o_done,
    output mhdcp_pkg::t_out   o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [62:0]       i_cfg_data
);
    import mhdcp_pkg::*;

    // Configuration registers
    logic [62:0] r_dfloor, r_pfloor, r_gl, r_ig, r_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfloor <= 63'd4295;
            r_pfloor <= 63'd4295;
            r_gl     <= 63'd2863311531;
            r_ig     <= 63'd6442450944;
            r_ip     <= 63'd4294967296;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DENSITY_FLOOR:  r_dfloor <= i_cfg_data;
                CFG_PRESSURE_FLOOR: r_pfloor <= i_cfg_data;
                CFG_GAMMA_LESS_ONE: r_gl     <= i_cfg_data;
                CFG_INV_GAMMA_L1:   r_ig     <= i_cfg_data;
                CFG_INV_PERM:       r_ip     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_s64 w_pf, w_ig, w_ip, w_gl;
    assign w_pf = {1'b0, r_pfloor};
    assign w_ig = {1'b0, r_ig};
    assign w_ip = {1'b0, r_ip};
    assign w_gl = {1'b0, r_gl};

    assign o_busy = 1'b0;

    t_work r_s0, r_s1, r_s2, r_s3;
    t_work n_s0, n_s1, n_s2, n_s3;
    t_work r_dly [0:DIV_LAT-1];
    t_work r_e1, r_e2, r_e3, r_e4, r_e5, r_e6, r_e7, r_e8, r_e9, r_e10;
    t_work n_e1, n_e2, n_e3, n_e4, n_e5, n_e6, n_e7, n_e8, n_e9, n_e10;
    t_out  r_out, n_out;
    logic  r_done;
    t_s64  w_quo [0:3];
    t_s64  w_num [0:3];
    t_work w_al;

    // Front stages: capture, floor density, square and multiply, sum
    always_comb begin
        n_s0 = '0;
        n_s0.vld  = i_start;
        n_s0.cmd  = i_item.cmd;
        n_s0.rho  = i_item.density_in;
        n_s0.code = REP_NONE;
        if (i_item.cmd == CMD_C2P &&
            (i_item.density_in[63] || i_item.density_in == 64'sd0)) begin
            n_s0.rho  = {1'b0, r_dfloor};
            n_s0.code = REP_DENS;
        end
        n_s0.v = {i_item.vec_th_in, i_item.vec_ph_in, i_item.vec_r_in};
        n_s0.b = {i_item.mag_th_in, i_item.mag_ph_in, i_item.mag_r_in};
        n_s0.s = i_item.scalar_in;

        n_s1 = r_s0;
        for (int i = 0; i < 3; i++) begin
            n_s1.ppa[i] = f_pp(r_s0.v[i], r_s0.v[i]);
            n_s1.ppb[i] = f_pp(r_s0.b[i], r_s0.b[i]);
            n_s1.ppc[i] = f_pp(r_s0.rho, r_s0.v[i]);
        end

        n_s2 = r_s1;
        for (int i = 0; i < 3; i++) begin
            n_s2.qa[i] = f_fin(r_s1.ppa[i]);
            n_s2.qb[i] = f_fin(r_s1.ppb[i]);
            n_s2.qc[i] = f_fin(r_s1.ppc[i]);
        end

        n_s3 = r_s2;
        n_s3.b2 = f_sadd(f_sadd(r_s2.qb[0], r_s2.qb[1]), r_s2.qb[2]);
        n_s3.a2 = f_sadd(f_sadd(r_s2.qa[0], r_s2.qa[1]), r_s2.qa[2]);
    end

    // Four dividers share the density as divisor
    assign w_num[0] = r_s3.v[0];
    assign w_num[1] = r_s3.v[1];
    assign w_num[2] = r_s3.v[2];
    assign w_num[3] = r_s3.a2;

    for (genvar g = 0; g < 4; g++) begin : g_div
        mhdcp_div_pipe u_div (
            .i_clk (i_clk),
            .i_num (w_num[g]),
            .i_den (r_s3.rho),
            .o_quo (w_quo[g])
        );
    end

    // Hold the transaction alongside the dividers
    always_ff @(posedge i_clk) begin
        r_dly[0] <= f_gate_vld(r_s3, i_rst_n);
    end
    for (genvar g = 1; g < DIV_LAT; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dly[g] <= f_gate_vld(r_dly[g-1], i_rst_n);
        end
    end
    assign w_al = r_dly[DIV_LAT-1];

    // Back stages: velocity, energies, pressure and repairs
    always_comb begin
        n_e1 = w_al;
        for (int i = 0; i < 3; i++) begin
            n_e1.o[i] = (w_al.cmd == CMD_P2C) ? w_al.qc[i] : w_quo[i];
        end
        n_e1.qd  = w_quo[3];
        n_e1.ppy = f_pp(w_al.b2, w_ip);
        n_e1.ppz = f_pp(w_pf, w_ig);

        n_e2 = r_e1;
        for (int i = 0; i < 3; i++) begin
            n_e2.ppa[i] = f_pp(r_e1.o[i], r_e1.o[i]);
        end
        n_e2.bip  = f_fin(r_e1.ppy);
        n_e2.pfig = f_fin(r_e1.ppz);

        n_e3 = r_e2;
        for (int i = 0; i < 3; i++) begin
            n_e3.qa[i] = f_fin(r_e2.ppa[i]);
        end

        n_e4 = r_e3;
        n_e4.v2 = (r_e3.cmd == CMD_P2C) ? r_e3.a2 :
                  f_sadd(f_sadd(r_e3.qa[0], r_e3.qa[1]), r_e3.qa[2]);
        n_e4.k  = f_sadd(r_e3.qd, r_e3.bip);

        n_e5 = r_e4;
        n_e5.ppx = f_pp(r_e4.rho, r_e4.v2);
        n_e5.ppy = f_pp(r_e4.s, w_ig);
        n_e5.erb = f_sadd(r_e4.pfig, f_half(r_e4.k));
        n_e5.hb  = f_half(r_e4.bip);

        n_e6 = r_e5;
        n_e6.rv2 = f_fin(r_e5.ppx);
        n_e6.sig = f_fin(r_e5.ppy);
        n_e6.e   = r_e5.s;
        if (r_e5.cmd == CMD_C2P && r_e5.s[63]) begin
            n_e6.e    = r_e5.erb;
            n_e6.code = REP_ENER;
        end

        n_e7 = r_e6;
        n_e7.p   = f_ssub(r_e6.e, f_half(r_e6.rv2));
        n_e7.en  = f_sadd(r_e6.sig, f_half(r_e6.rv2));
        n_e7.efl = f_sadd(r_e6.pfig, f_half(r_e6.rv2));

        n_e8 = r_e7;
        n_e8.p   = f_ssub(r_e7.p, r_e7.hb);
        n_e8.en  = f_sadd(r_e7.en, r_e7.hb);
        n_e8.efl = f_sadd(r_e7.efl, r_e7.hb);

        n_e9 = r_e8;
        n_e9.ppx = f_pp(w_gl, r_e8.p);

        n_e10 = r_e9;
        n_e10.p = f_fin(r_e9.ppx);
    end

    // Form the result
    always_comb begin
        n_out.density_out  = r_e10.rho;
        n_out.vec_r_out    = r_e10.o[0];
        n_out.vec_ph_out   = r_e10.o[1];
        n_out.vec_th_out   = r_e10.o[2];
        n_out.mag_r_out    = r_e10.b[0];
        n_out.mag_ph_out   = r_e10.b[1];
        n_out.mag_th_out   = r_e10.b[2];
        n_out.scalar_out   = r_e10.p;
        n_out.energy_fixed = r_e10.e;
        n_out.repair_code  = r_e10.code;
        if (r_e10.cmd == CMD_P2C) begin
            n_out.scalar_out   = r_e10.en;
            n_out.energy_fixed = r_e10.en;
            n_out.repair_code  = REP_NONE;
        end else if (r_e10.p[63]) begin
            n_out.scalar_out   = w_pf;
            n_out.energy_fixed = r_e10.efl;
            n_out.repair_code  = REP_PRES;
        end
    end

    // Advance all stages; only the valid bits see reset
    always_ff @(posedge i_clk) begin
        r_s0   <= f_gate_vld(n_s0, i_rst_n);
        r_s1   <= f_gate_vld(n_s1, i_rst_n);
        r_s2   <= f_gate_vld(n_s2, i_rst_n);
        r_s3   <= f_gate_vld(n_s3, i_rst_n);
        r_e1   <= f_gate_vld(n_e1, i_rst_n);
        r_e2   <= f_gate_vld(n_e2, i_rst_n);
        r_e3   <= f_gate_vld(n_e3, i_rst_n);
        r_e4   <= f_gate_vld(n_e4, i_rst_n);
        r_e5   <= f_gate_vld(n_e5, i_rst_n);
        r_e6   <= f_gate_vld(n_e6, i_rst_n);
        r_e7   <= f_gate_vld(n_e7, i_rst_n);
        r_e8   <= f_gate_vld(n_e8, i_rst_n);
        r_e9   <= f_gate_vld(n_e9, i_rst_n);
        r_e10  <= f_gate_vld(n_e10, i_rst_n);
        r_out  <= n_out;
        r_done <= r_e10.vld & i_rst_n;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

    // Every accepted transaction completes after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##PIPE_LAT o_done)
        else $error("transaction did not complete on time");

    // Field passes through aligned with its transaction
    a_mag_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.mag_r_out == $past(i_item.mag_r_in, PIPE_LAT))
        else $error("field misaligned with transaction");

    // Primitive-to-conservative never reports a repair
    a_p2c_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.cmd, PIPE_LAT) == CMD_P2C)
        |-> o_result.repair_code == REP_NONE)
        else $error("repair reported for primitive input");

    // Converted pressure is never negative
    a_p_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e10.vld && r_e10.cmd == CMD_C2P) |=> !o_result.scalar_out[63])
        else $error("negative pressure left unrepaired");

    // Reset flushes the result strobe
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

endmodule

// ===== bench/mhd_cons_prim_convert_top_tb.sv =====
// Self-checking bench for the MHD conservative/primitive conversion pipeline.
module mhd_cons_prim_convert_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mhdcp_pkg::*;

    localparam int DRAIN_WAIT  = PIPE_LAT + 20;
    localparam longint CYCLE_LIMIT = 400000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_start = 1'b0;
    logic            o_busy;
    t_in             i_item = '0;
    logic            o_done;
    t_out            o_result;
    logic            i_cfg_we = 1'b0;
    logic [2:0]      i_cfg_idx = '0;
    logic [62:0]     i_cfg_data = '0;

    mhd_cons_prim_convert_top DUT (.*);

    always #10 i_clk = ~i_clk;

    // Bench copy of the conversion constants
    logic [62:0] dens_floor_q, pres_floor_q, gm1_q, inv_gm1_q, inv_mu_q;

    t_in    pending_cells[$];
    t_out   expected_cells[$];
    int     send_idle_pct = 0;
    int     mismatch_cnt = 0;
    int     checked_cnt = 0;
    int     c2p_cnt = 0, p2c_cnt = 0;
    int     repair_seen[4] = '{0, 0, 0, 0};
    longint cycle_cnt = 0;

    // ---------------- fixed-point arithmetic ----------------
    function automatic t_s64 sat_from_mag(bit neg, logic [127:0] m);
        if (neg) return (m >= 128'h8000_0000_0000_0000) ? S64_MIN : -$signed({1'b0, m[62:0]});
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : $signed(m[63:0]);
    endfunction

    function automatic logic [63:0] abs64(t_s64 x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic t_s64 add_sat(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic t_s64 sub_sat(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic t_s64 halve(t_s64 x);
        return x / 2;
    endfunction

    function automatic t_s64 fx_mul(t_s64 a, t_s64 b);
        logic [127:0] p;
        p = 128'(abs64(a)) * 128'(abs64(b));
        return sat_from_mag(a[63] ^ b[63], p >> 32);
    endfunction

    function automatic t_s64 fx_div(t_s64 a, t_s64 b);
        logic [127:0] n;
        logic [63:0]  d;
        bit           neg;
        n = 128'(abs64(a)) << 32;
        d = abs64(b);
        neg = a[63] ^ b[63];
        if (n == 0) return 0;
        if (d == 0 || (n >> 64) >= 128'(d)) return neg ? S64_MIN : S64_MAX;
        return sat_from_mag(neg, n / 128'(d));
    endfunction

    function automatic t_s64 sum_squares(t_s64 x, t_s64 y, t_s64 z);
        return add_sat(add_sat(fx_mul(x, x), fx_mul(y, y)), fx_mul(z, z));
    endfunction

    function automatic t_s64 total_energy(t_s64 p, t_s64 rho, t_s64 v2, t_s64 b2);
        t_s64 e;
        e = fx_mul(p, $signed({1'b0, inv_gm1_q}));
        e = add_sat(e, halve(fx_mul(rho, v2)));
        return add_sat(e, halve(fx_mul(b2, $signed({1'b0, inv_mu_q}))));
    endfunction

    // Convert one cell state the way the pipeline should
    function automatic t_out convert_cell(t_in c);
        t_out   r;
        t_s64   rho, b2, m2, v2, e, p, k, bmu;
        t_repair code;
        rho  = c.density_in;
        code = REP_NONE;
        b2   = sum_squares(c.mag_r_in, c.mag_ph_in, c.mag_th_in);
        bmu  = fx_mul(b2, $signed({1'b0, inv_mu_q}));
        r.mag_r_out  = c.mag_r_in;
        r.mag_ph_out = c.mag_ph_in;
        r.mag_th_out = c.mag_th_in;
        if (c.cmd == CMD_C2P) begin
            m2 = sum_squares(c.vec_r_in, c.vec_ph_in, c.vec_th_in);
            e  = c.scalar_in;
            if (rho <= 0) begin
                rho  = $signed({1'b0, dens_floor_q});
                code = REP_DENS;
            end
            r.vec_r_out  = fx_div(c.vec_r_in, rho);
            r.vec_ph_out = fx_div(c.vec_ph_in, rho);
            r.vec_th_out = fx_div(c.vec_th_in, rho);
            v2 = sum_squares(r.vec_r_out, r.vec_ph_out, r.vec_th_out);
            if (e < 0) begin
                k = add_sat(fx_div(m2, rho), bmu);
                e = add_sat(fx_mul($signed({1'b0, pres_floor_q}),
                                   $signed({1'b0, inv_gm1_q})), halve(k));
                code = REP_ENER;
            end
            p = sub_sat(e, halve(fx_mul(rho, v2)));
            p = sub_sat(p, halve(bmu));
            p = fx_mul($signed({1'b0, gm1_q}), p);
            if (p < 0) begin
                p = $signed({1'b0, pres_floor_q});
                e = total_energy(p, rho, v2, b2);
                code = REP_PRES;
            end
            r.scalar_out   = p;
            r.energy_fixed = e;
        end else begin
            r.vec_r_out  = fx_mul(rho, c.vec_r_in);
            r.vec_ph_out = fx_mul(rho, c.vec_ph_in);
            r.vec_th_out = fx_mul(rho, c.vec_th_in);
            v2 = sum_squares(c.vec_r_in, c.vec_ph_in, c.vec_th_in);
            r.scalar_out   = total_energy(c.scalar_in, rho, v2, b2);
            r.energy_fixed = r.scalar_out;
        end
        r.density_out = rho;
        r.repair_code = code;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_s64 rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly physical-looking magnitudes, sometimes full range
    function automatic t_s64 rand_q(int lo_bits, int hi_bits);
        t_s64 v;
        int   w;
        if ($urandom_range(9) == 0) return rand64();
        w = $urandom_range(hi_bits, lo_bits);
        v = rand64() & ((64'sd1 <<< w) - 1);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic t_in rand_cell();
        t_in c;
        c.cmd        = $urandom_range(1);
        c.density_in = ($urandom_range(7) == 0) ? -rand_q(0, 40) : rand_q(20, 40);
        if (c.density_in < 0 && $urandom_range(1)) c.density_in = 0;
        c.density_in = ($urandom_range(7) == 0) ? c.density_in : abs64(c.density_in);
        c.vec_r_in   = rand_q(8, 38);
        c.vec_ph_in  = rand_q(8, 38);
        c.vec_th_in  = rand_q(8, 38);
        c.mag_r_in   = rand_q(8, 36);
        c.mag_ph_in  = rand_q(8, 36);
        c.mag_th_in  = rand_q(8, 36);
        c.scalar_in  = rand_q(20, 44);
        return c;
    endfunction

    function automatic t_in make_cell(logic cmd, t_s64 rho, t_s64 v, t_s64 b, t_s64 s);
        t_in c;
        c.cmd = cmd;
        c.density_in = rho;
        c.vec_r_in = v;  c.vec_ph_in = -v;  c.vec_th_in = v >>> 1;
        c.mag_r_in = b;  c.mag_ph_in = b >>> 2;  c.mag_th_in = -b;
        c.scalar_in = s;
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DENSITY_FLOOR:  dens_floor_q = val;
            CFG_PRESSURE_FLOOR: pres_floor_q = val;
            CFG_GAMMA_LESS_ONE: gm1_q = val;
            CFG_INV_GAMMA_L1:   inv_gm1_q = val;
            CFG_INV_PERM:       inv_mu_q = val;
            default: ;
        endcase
    endtask

    task automatic set_constants(logic [62:0] df, logic [62:0] pf, logic [62:0] g,
                                 logic [62:0] ig, logic [62:0] im);
        write_reg(CFG_DENSITY_FLOOR, df);
        write_reg(CFG_PRESSURE_FLOOR, pf);
        write_reg(CFG_GAMMA_LESS_ONE, g);
        write_reg(CFG_INV_GAMMA_L1, ig);
        write_reg(CFG_INV_PERM, im);
    endtask

    // Hold until the pipeline has emptied and settled
    task automatic wait_drained();
        while (pending_cells.size() != 0 || expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_in c;
        if (i_start && !o_busy) begin
            c = i_item;
            expected_cells.push_back(convert_cell(c));
            if (c.cmd == CMD_C2P) c2p_cnt++; else p2c_cnt++;
        end
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_item  <= pending_cells.pop_front();
            i_start <= 1'b1;
        end else begin
            i_start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out want;
        cycle_cnt++;
        if (i_rst_n && o_done) begin
            if (expected_cells.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %h", o_result);
            end else begin
                want = expected_cells.pop_front();
                checked_cnt++;
                repair_seen[want.repair_code]++;
                if (o_result !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch at result %0d:", checked_cnt);
                        $display("  rho exp %h got %h", want.density_out, o_result.density_out);
                        $display("  v   exp %h %h %h got %h %h %h", want.vec_r_out,
                                 want.vec_ph_out, want.vec_th_out, o_result.vec_r_out,
                                 o_result.vec_ph_out, o_result.vec_th_out);
                        $display("  b   exp %h %h %h got %h %h %h", want.mag_r_out,
                                 want.mag_ph_out, want.mag_th_out, o_result.mag_r_out,
                                 o_result.mag_ph_out, o_result.mag_th_out);
                        $display("  s   exp %h got %h, e exp %h got %h, code exp %0d got %0d",
                                 want.scalar_out, o_result.scalar_out, want.energy_fixed,
                                 o_result.energy_fixed, want.repair_code,
                                 o_result.repair_code);
                    end
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_cells.size());
            $display("mhd_cons_prim_convert_top_tb: done, errors");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        t_s64 one;
        one = 64'sd1 <<< 32;
        dens_floor_q = 63'd4295;
        pres_floor_q = 63'd4295;
        gm1_q        = 63'd2863311531;
        inv_gm1_q    = 63'd6442450944;
        inv_mu_q     = 63'd4294967296;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells: extremes, both commands, each repair path
        pending_cells.push_back(make_cell(CMD_C2P, one, one, one, 10 * one));
        pending_cells.push_back(make_cell(CMD_C2P, 0, one, one, 10 * one));
        pending_cells.push_back(make_cell(CMD_C2P, -one, one, 0, one));
        pending_cells.push_back(make_cell(CMD_C2P, one, one, one, -one));
        pending_cells.push_back(make_cell(CMD_C2P, one, 8 * one, one, one));
        pending_cells.push_back(make_cell(CMD_C2P, S64_MAX, S64_MAX, S64_MAX, S64_MAX));
        pending_cells.push_back(make_cell(CMD_C2P, S64_MIN, S64_MIN, S64_MIN, S64_MIN));
        pending_cells.push_back(make_cell(CMD_C2P, 1, S64_MAX, 0, 0));
        pending_cells.push_back(make_cell(CMD_C2P, one, 0, 0, 0));
        pending_cells.push_back(make_cell(CMD_C2P, -1, -1, -1, -1));
        pending_cells.push_back(make_cell(CMD_P2C, one, one, one, one));
        pending_cells.push_back(make_cell(CMD_P2C, S64_MAX, S64_MAX, S64_MAX, S64_MAX));
        pending_cells.push_back(make_cell(CMD_P2C, S64_MIN, S64_MIN, S64_MIN, S64_MIN));
        pending_cells.push_back(make_cell(CMD_P2C, -one, -one, one, -one));
        pending_cells.push_back(make_cell(CMD_P2C, 0, 0, 0, 0));
        pending_cells.push_back(make_cell(CMD_P2C, -1, 1, -1, 1));
        wait_drained();

        // Random phases under several constant sets, idle patterns rotating
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: set_constants(63'd1, 63'd1, 63'd1, 63'd1, 63'd1);
                2: set_constants('1, '1, '1, '1, '1);
                3: set_constants(63'd4294967, 63'd42949672, 63'd2147483648,
                                 63'd8589934592, 63'd341782638);
                4: set_constants(63'h7FFF_FFFF, 63'h1_0000_0000, 63'h2_0000_0000,
                                 63'h8000_0000, 63'h10_0000_0000);
                5: set_constants(63'd4295, 63'd4295, 63'd2863311531,
                                 63'd6442450944, 63'd4294967296);
                default: ;
            endcase
            send_idle_pct = (ph % 3 == 0) ? 36 : (ph % 3 == 1) ? 50 : 0;
            for (int n = 0; n < 100; n++) pending_cells.push_back(rand_cell());
            wait_drained();
        end

        $display("checked %0d cells (%0d cons->prim, %0d prim->cons) under 6 constant sets",
                 checked_cnt, c2p_cnt, p2c_cnt);
        $display("repairs seen: none %0d, density %0d, energy %0d, pressure %0d",
                 repair_seen[0], repair_seen[1], repair_seen[2], repair_seen[3]);
        if (mismatch_cnt == 0 && expected_cells.size() == 0) begin
            $display("mhd_cons_prim_convert_top_tb: done, clean");
        end else begin
            $display("mhd_cons_prim_convert_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mhdcp_pkg.sv
hw/rtl/mhdcp_div_pipe.sv
hw/rtl/mhd_cons_prim_convert_top.sv
bench/mhd_cons_prim_convert_top_tb.sv
